### rtl/ualu_pkg.sv
// ----------------------------------------------------------------------------
// ualu_pkg
// shared types, codes and constants of the unsigned alu with register file
// ----------------------------------------------------------------------------
package ualu_pkg;

  localparam int          REG_COUNT_DEF = 16;
  localparam logic [63:0] STEP_BYTES    = 64'd4;
  localparam logic [63:0] LLONG_MAX_U   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          LOG_TOP       = 44;

  localparam int FLAG_DIV_ZERO = 0;
  localparam int FLAG_SUB_ZERO = 1;

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,
    CMD_SUB  = 5'd1,
    CMD_MUL  = 5'd2,
    CMD_DIV  = 5'd3,
    CMD_MOD  = 5'd4,
    CMD_FMA  = 5'd5,
    CMD_SQRT = 5'd6,
    CMD_LOG  = 5'd7,
    CMD_INC  = 5'd8,
    CMD_DEC  = 5'd9,
    CMD_AND  = 5'd10,
    CMD_OR   = 5'd11,
    CMD_XOR  = 5'd12,
    CMD_SHL  = 5'd13,
    CMD_SHR  = 5'd14,
    CMD_ROL  = 5'd15,
    CMD_ROR  = 5'd16,
    CMD_POP  = 5'd17,
    CMD_CLZ  = 5'd18
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_DIV_ZERO  = 3'd1,
    STS_LOG_ZERO  = 3'd2,
    STS_INC_OVF   = 3'd3,
    STS_DEC_UNF   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_AB,
    S_READ_ACC,
    S_EXEC,
    S_WAIT,
    S_COMMIT
  } state_t;

  typedef enum logic [2:0] {
    IT_MUL,
    IT_DIV,
    IT_MOD,
    IT_SQRT,
    IT_LOG,
    IT_POP,
    IT_CLZ
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } iter_rsp_t;

  typedef logic [63:0] thr_tab_t [LOG_TOP];

  // ceil(e^k) for k = 1..LOG_TOP, from e built in 64.128 fixed point
  function automatic thr_tab_t build_exp_thr();
    thr_tab_t     tab;
    logic [191:0] e;
    logic [191:0] term;
    logic [191:0] pw;
    logic [383:0] prod;
    e    = 192'd1 << 128;
    term = 192'd1 << 128;
    for (int n = 1; n <= 40; n++) begin
      term = term / 192'(n);
      e    = e + term;
    end
    pw = e;
    for (int k = 1; k <= LOG_TOP; k++) begin
      tab[k-1] = pw[191:128] + 64'd1;
      if (k < LOG_TOP) begin
        prod = {192'd0, pw} * {192'd0, e};
        pw   = prod[319:128];
      end
    end
    return tab;
  endfunction

  localparam thr_tab_t EXP_THR = build_exp_thr();

endpackage

### rtl/ualu_if.sv
// ----------------------------------------------------------------------------
// ualu channels
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface ualu_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] command;
  logic [3:0] dest_index;
  logic [3:0] first_source;
  logic [3:0] second_source;

  modport source (output valid, command, dest_index, first_source, second_source,
                  input ready);
  modport sink   (input valid, command, dest_index, first_source, second_source,
                  output ready);
endinterface

interface ualu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] written_value;
  logic [63:0] pointer_after;
  logic [1:0]  sticky_flags;

  modport source (output valid, status, written_value, pointer_after, sticky_flags,
                  input ready);
  modport sink   (input valid, status, written_value, pointer_after, sticky_flags,
                  output ready);
endinterface

### rtl/unsigned_alu_with_register_file.sv
// ----------------------------------------------------------------------------
// unsigned_alu_with_register_file
// 64-bit unsigned alu executing one instruction per request on a register file
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one instruction per request: command, dest_index,
//   first_source, second_source; indexes are folded modulo REG_COUNT
//   out_ch returns one result per request: status, written_value,
//   pointer_after and sticky_flags after the instruction
//   one request is in flight at a time; in_ch.ready is high in idle, even
//   while the previous result still sits in the output register
//   after accept a request passes two register file reads (operands,
//   then the accumulator of the destination), decode and commit; mul and
//   fma, popcount, sqrt, clz, and div, mod and log without error also wait
//   for the iterative unit, whose steps depend on the op (for clz on the
//   number of leading zeros); the next request is taken the cycle after
//   the commit, once the block is back in idle
//   a request is committed only when the output register is free, so a
//   stalled receiver holds the block in commit, with no loss of results
//   after reset all registers read zero (per-entry valid bits), the
//   instruction pointer and sticky flags are zero; no clearing pass
// ----------------------------------------------------------------------------
module unsigned_alu_with_register_file #(
  parameter int REG_COUNT = ualu_pkg::REG_COUNT_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ualu_in_if.sink   in_ch,
  ualu_out_if.source out_ch
);
  import ualu_pkg::*;

  localparam int IDX_W = $clog2(REG_COUNT);

  // fold a 4-bit index into the file, repeated subtract on a narrow value
  function automatic logic [IDX_W-1:0] fold_idx(input logic [3:0] v);
    logic [8:0] t;
    t = {5'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (t >= 9'(REG_COUNT)) begin
        t = t - 9'(REG_COUNT);
      end
    end
    return t[IDX_W-1:0];
  endfunction

  // control state
  state_t      state_r, state_nxt;
  logic        out_valid_r;
  logic [63:0] ip_r;
  logic [1:0]  flags_r;
  logic [REG_COUNT-1:0] vld_r;

  // captured request and operands
  cmd_t             cmd_r;
  logic [IDX_W-1:0] d_r;
  logic [63:0]      a_r, b_r, acc_r, res_r;

  // register file
  logic [63:0]      mem [REG_COUNT];
  logic [IDX_W-1:0] rd0_addr, rd1_addr;
  logic [63:0]      rd0_q, rd1_q;
  logic             rd0_v, rd1_v;
  logic [63:0]      rd0_val, rd1_val;
  logic             wr_en;

  // output register payload
  status_t     out_sts_r;
  logic [63:0] out_val_r;
  logic [63:0] out_ip_r;
  logic [1:0]  out_flags_r;

  // iterative unit
  iter_req_t ureq;
  iter_rsp_t ursp;
  logic      use_unit;
  iter_op_t  unit_op;

  // commit results
  logic        in_fire;
  logic        commit_fire;
  logic [63:0] cm_val;
  status_t     cm_sts;
  logic        cm_known;
  logic [1:0]  cm_flag_set;
  logic [127:0] rot_l, rot_r;
  logic        wide_shift;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign commit_fire = (state_r == S_COMMIT) && (!out_valid_r || out_ch.ready);

  assign rd0_val = rd0_v ? rd0_q : 64'd0;
  assign rd1_val = rd1_v ? rd1_q : 64'd0;

  // which commands go through the iterative unit, errors bypass it
  always_comb begin
    use_unit = 1'b0;
    unit_op  = IT_MUL;
    case (cmd_r)
      CMD_MUL, CMD_FMA: begin
        use_unit = 1'b1;
        unit_op  = IT_MUL;
      end
      CMD_DIV: begin
        use_unit = (b_r != 64'd0);
        unit_op  = IT_DIV;
      end
      CMD_MOD: begin
        use_unit = (b_r != 64'd0);
        unit_op  = IT_MOD;
      end
      CMD_SQRT: begin
        use_unit = 1'b1;
        unit_op  = IT_SQRT;
      end
      CMD_LOG: begin
        use_unit = (a_r != 64'd0);
        unit_op  = IT_LOG;
      end
      CMD_POP: begin
        use_unit = 1'b1;
        unit_op  = IT_POP;
      end
      CMD_CLZ: begin
        use_unit = 1'b1;
        unit_op  = IT_CLZ;
      end
      default: begin
        use_unit = 1'b0;
        unit_op  = IT_MUL;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_fire) state_nxt = S_READ_AB;
      S_READ_AB:  state_nxt = S_READ_ACC;
      S_READ_ACC: state_nxt = S_EXEC;
      S_EXEC:     state_nxt = use_unit ? S_WAIT : S_COMMIT;
      S_WAIT:     if (ursp.done) state_nxt = S_COMMIT;
      S_COMMIT:   if (commit_fire) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    rd0_addr    = d_r;
    rd1_addr    = d_r;
    ureq.start  = 1'b0;
    ureq.op     = unit_op;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        rd0_addr    = fold_idx(in_ch.first_source);
        rd1_addr    = fold_idx(in_ch.second_source);
      end
      S_EXEC: begin
        ureq.start = use_unit;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // combinational ops and the final value of unit ops
  always_comb begin
    rot_l       = {a_r, a_r} << b_r[5:0];
    rot_r       = {a_r, a_r} >> b_r[5:0];
    wide_shift  = (b_r[63:6] != 58'd0);
    cm_val      = 64'd0;
    cm_sts      = STS_OK;
    cm_known    = 1'b1;
    cm_flag_set = 2'b00;
    case (cmd_r)
      CMD_ADD: cm_val = a_r + b_r;
      CMD_SUB: begin
        cm_val = a_r - b_r;
        cm_flag_set[FLAG_SUB_ZERO] = (b_r == 64'd0);
      end
      CMD_MUL: cm_val = res_r;
      CMD_DIV, CMD_MOD: begin
        if (b_r == 64'd0) begin
          cm_sts = STS_DIV_ZERO;
          cm_flag_set[FLAG_DIV_ZERO] = 1'b1;
        end else begin
          cm_val = res_r;
        end
      end
      CMD_FMA:  cm_val = acc_r + res_r;
      CMD_SQRT: cm_val = res_r;
      CMD_LOG: begin
        if (a_r == 64'd0) cm_sts = STS_LOG_ZERO;
        else              cm_val = res_r;
      end
      CMD_INC: begin
        if (acc_r < LLONG_MAX_U) cm_val = acc_r + 64'd1;
        else                     cm_sts = STS_INC_OVF;
      end
      CMD_DEC: begin
        if (acc_r != 64'd0) cm_val = acc_r - 64'd1;
        else                cm_sts = STS_DEC_UNF;
      end
      CMD_AND: cm_val = a_r & b_r;
      CMD_OR:  cm_val = a_r | b_r;
      CMD_XOR: cm_val = a_r ^ b_r;
      CMD_SHL: cm_val = wide_shift ? 64'd0 : (a_r << b_r[5:0]);
      CMD_SHR: cm_val = wide_shift ? 64'd0 : (a_r >> b_r[5:0]);
      CMD_ROL: cm_val = rot_l[127:64];
      CMD_ROR: cm_val = rot_r[63:0];
      CMD_POP: cm_val = res_r;
      CMD_CLZ: cm_val = res_r;
      default: cm_known = 1'b0;
    endcase
    // errors and unused commands report a zero value
    if (!cm_known || cm_sts != STS_OK) begin
      cm_val = 64'd0;
    end
  end

  assign wr_en = commit_fire && cm_known && (cm_sts == STS_OK);

  // register file: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[d_r] <= cm_val;
    end
    rd0_q <= mem[rd0_addr];
    rd1_q <= mem[rd1_addr];
    rd0_v <= vld_r[rd0_addr];
    rd1_v <= vld_r[rd1_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ip_r        <= 64'd0;
      flags_r     <= 2'b00;
      vld_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit_fire) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_r | cm_flag_set;
        if (wr_en) begin
          ip_r       <= ip_r + STEP_BYTES;
          vld_r[d_r] <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_t'(in_ch.command);
      d_r   <= fold_idx(in_ch.dest_index);
    end
    if (state_r == S_READ_AB) begin
      a_r <= rd0_val;
      b_r <= rd1_val;
    end
    if (state_r == S_READ_ACC) begin
      acc_r <= rd0_val;
    end
    if (state_r == S_WAIT && ursp.done) begin
      res_r <= ursp.result;
    end
    if (commit_fire) begin
      out_sts_r   <= cm_sts;
      out_val_r   <= cm_val;
      out_ip_r    <= wr_en ? ip_r + STEP_BYTES : ip_r;
      out_flags_r <= flags_r | cm_flag_set;
    end
  end

  ualu_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ureq),
    .opa   (a_r),
    .opb   (b_r),
    .rsp   (ursp)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_sts_r;
  assign out_ch.written_value = out_val_r;
  assign out_ch.pointer_after = out_ip_r;
  assign out_ch.sticky_flags  = out_flags_r;

endmodule

### rtl/ualu_seq.sv
// ----------------------------------------------------------------------------
// ualu_seq
// multi-cycle unit: mul, div/mod, sqrt, floor ln, popcount, clz
// ----------------------------------------------------------------------------
module ualu_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  ualu_pkg::iter_req_t req,
  input  logic [63:0]         opa,
  input  logic [63:0]         opb,
  output ualu_pkg::iter_rsp_t rsp
);
  import ualu_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  iter_op_t    op_r, op_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [64:0] rem_r, rem_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [64:0] div_sh;
  logic [35:0] sq_sh, sq_trial;

  // multiplier operands per partial product
  always_comb begin
    mul_a = x_r[31:0];
    mul_b = b_r[31:0];
    case (cnt_r[1:0])
      2'd1:    mul_b = b_r[63:32];
      2'd2:    mul_a = x_r[63:32];
      default: mul_b = b_r[31:0];
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    div_sh   = {rem_r[63:0], x_r[63]};
    sq_sh    = {rem_r[33:0], x_r[63:62]};
    sq_trial = {2'b00, acc_r[31:0], 2'b01};
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      x_nxt    = opa;
      b_nxt    = opb;
      acc_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 7'd1;
      case (op_r)
        IT_MUL: begin
          // low x low, then the two cross products into the upper half
          if (cnt_r[1:0] == 2'd0) begin
            acc_nxt = mul_p;
          end else begin
            acc_nxt = acc_r + {mul_p[31:0], 32'd0};
          end
          if (cnt_r == 7'd2) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        IT_DIV, IT_MOD: begin
          if (div_sh >= {1'b0, b_r}) begin
            rem_nxt = div_sh - {1'b0, b_r};
            x_nxt   = {x_r[62:0], 1'b1};
          end else begin
            rem_nxt = div_sh;
            x_nxt   = {x_r[62:0], 1'b0};
          end
          if (cnt_r == 7'd63) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        IT_SQRT: begin
          x_nxt = {x_r[61:0], 2'b00};
          if (sq_sh >= sq_trial) begin
            rem_nxt = {29'd0, sq_sh - sq_trial};
            acc_nxt = {acc_r[62:0], 1'b1};
          end else begin
            rem_nxt = {29'd0, sq_sh};
            acc_nxt = {acc_r[62:0], 1'b0};
          end
          if (cnt_r == 7'd31) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        IT_LOG: begin
          if (x_r >= EXP_THR[cnt_r[5:0]]) begin
            acc_nxt = acc_r + 64'd1;
          end
          if (cnt_r == 7'(LOG_TOP - 1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        IT_POP: begin
          acc_nxt = acc_r + {63'd0, x_r[0]};
          x_nxt   = {1'b0, x_r[63:1]};
          if (cnt_r == 7'd63) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        IT_CLZ: begin
          if (x_r[63] || cnt_r == 7'd64) begin
            cnt_nxt  = cnt_r;
            acc_nxt  = {57'd0, cnt_r};
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            x_nxt = {x_r[62:0], 1'b0};
          end
        end
        default: begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  always_comb begin
    rsp.done = done_r;
    case (op_r)
      IT_DIV:  rsp.result = x_r;
      IT_MOD:  rsp.result = rem_r[63:0];
      default: rsp.result = acc_r;
    endcase
  end

endmodule

### rtl/ualu_chk.sv
// ----------------------------------------------------------------------------
// ualu_chk
// port-level checks of the unsigned alu, bound to the top level
// ----------------------------------------------------------------------------
module ualu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [63:0] out_value,
  input logic [1:0]  out_flags
);
  import ualu_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result dropped or changed under stall");

  // an error never reports a value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |-> out_value == 64'd0)
    else $error("nonzero value with error status");

  // divide by zero shows in the sticky flag
  a_div_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_DIV_ZERO |-> out_flags[FLAG_DIV_ZERO])
    else $error("divide by zero without sticky flag");

  // no result appears the cycle after a request is taken
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too early after request");

endmodule

bind unsigned_alu_with_register_file ualu_chk u_ualu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_value  (out_ch.written_value),
  .out_flags  (out_ch.sticky_flags)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned alu testbench
// drives instruction requests through a directed table and then random
// sequences under several idling phases; every result is compared
// field by field against a hand-read value or a model of the register file
// ----------------------------------------------------------------------------
module testbench;
  import ualu_pkg::*;

  localparam int          REGS       = 16;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          DRAIN_WAIT = 80;
  localparam int          RAND_ITEMS = 850;
  localparam logic [4:0]  CMD_SPARE  = 5'd31;   // top of the unused command range
  localparam logic [4:0]  CMD_LAST   = CMD_CLZ;

  // one expected result
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value;
    logic [63:0] pointer;
    logic [1:0]  flags;
  } alu_result_t;

  // one row of the directed table; typed rows carry a hand-read result
  typedef struct packed {
    logic [4:0]  cmd;
    logic [3:0]  dst;
    logic [3:0]  src_a;
    logic [3:0]  src_b;
    logic        typed;
    alu_result_t res;
  } instr_row_t;

  logic clk;
  logic rst_n;

  ualu_in_if  in_ch ();
  ualu_out_if out_ch ();

  unsigned_alu_with_register_file u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock, 12 ns period
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // model state of the block
  // ---------------------------------------------------------------------------
  logic [63:0] model_regs [REGS];
  logic [63:0] model_ip;
  logic [1:0]  model_flags;
  logic [63:0] ln_bound [1:LOG_TOP];   // smallest integer x with ln(x) >= k

  alu_result_t pending_results [$];
  int          req_count;
  int          res_count;
  int          error_count;
  int          stall_cycles;
  int          idle_pct_in;
  int          idle_pct_out;
  logic        done_sending;
  logic        cur_typed;
  alu_result_t cur_expect;
  bit [31:0]   cmd_seen;

  // powers of e in 64.128 fixed point, rounded up to integers
  function automatic void build_ln_bounds();
    logic [191:0] e_fx;
    logic [191:0] term;
    logic [191:0] pw;
    logic [383:0] wide;
    e_fx = 192'd1 << 128;
    term = 192'd1 << 128;
    for (int n = 1; n <= 40; n++) begin
      term = term / n;
      e_fx = e_fx + term;
    end
    pw = e_fx;
    for (int k = 1; k <= LOG_TOP; k++) begin
      ln_bound[k] = pw[191:128] + 64'd1;
      wide = {192'd0, pw} * {192'd0, e_fx};
      pw   = wide[319:128];
    end
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] rotl64(logic [63:0] x, logic [5:0] s);
    if (s == 0) return x;
    return (x << s) | (x >> (7'd64 - s));
  endfunction

  // executes one instruction on the model state and returns its result
  function automatic alu_result_t execute_instr(logic [4:0] cmd, logic [3:0] dst,
                                                logic [3:0] sa, logic [3:0] sb);
    alu_result_t r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] acc;
    logic [63:0] v;
    logic [2:0]  sts;
    logic        known;
    int          n;
    a     = model_regs[sa];
    b     = model_regs[sb];
    acc   = model_regs[dst];
    v     = '0;
    sts   = STS_OK;
    known = 1'b1;
    case (cmd)
      CMD_ADD: v = a + b;
      CMD_SUB: begin
        if (b == 0) model_flags[FLAG_SUB_ZERO] = 1'b1;
        v = a - b;
      end
      CMD_MUL: v = a * b;
      CMD_DIV, CMD_MOD: begin
        if (b == 0) begin
          model_flags[FLAG_DIV_ZERO] = 1'b1;
          sts = STS_DIV_ZERO;
        end else begin
          v = (cmd == CMD_DIV) ? a / b : a % b;
        end
      end
      CMD_FMA:  v = acc + a * b;
      CMD_SQRT: v = isqrt64(a);
      CMD_LOG: begin
        if (a == 0) sts = STS_LOG_ZERO;
        else begin
          n = 0;
          for (int k = 1; k <= LOG_TOP; k++) if (a >= ln_bound[k]) n++;
          v = n;
        end
      end
      CMD_INC: if (acc < LLONG_MAX_U) v = acc + 1; else sts = STS_INC_OVF;
      CMD_DEC: if (acc > 0) v = acc - 1; else sts = STS_DEC_UNF;
      CMD_AND: v = a & b;
      CMD_OR:  v = a | b;
      CMD_XOR: v = a ^ b;
      CMD_SHL: v = (b >= 64) ? 64'd0 : a << b[5:0];
      CMD_SHR: v = (b >= 64) ? 64'd0 : a >> b[5:0];
      CMD_ROL: v = rotl64(a, b[5:0]);
      CMD_ROR: v = rotl64(a, 6'd0 - b[5:0]);
      CMD_POP: v = $countones(a);
      CMD_CLZ: begin
        n = 0;
        while (n < 64 && a[63-n] == 1'b0) n++;
        v = n;
      end
      default: known = 1'b0;
    endcase
    if (known && sts == STS_OK) begin
      model_regs[dst] = v;
      model_ip        = model_ip + STEP_BYTES;
    end else begin
      v = '0;
    end
    r.status  = sts;
    r.value   = v;
    r.pointer = model_ip;
    r.flags   = model_flags;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table: hand-read results where obvious, model for the rest
  // ---------------------------------------------------------------------------
  localparam logic [63:0] ALL_ONES = '1;
  instr_row_t directed [] = '{
    // dec of a zero register underflows
    '{CMD_DEC, 4'd0, 4'd0, 4'd0, 1'b1, '{STS_DEC_UNF, 64'd0, 64'd0, 2'b00}},
    // divide and mod by zero, log of zero
    '{CMD_DIV, 4'd3, 4'd0, 4'd0, 1'b1, '{STS_DIV_ZERO, 64'd0, 64'd0, 2'b01}},
    '{CMD_MOD, 4'd3, 4'd1, 4'd2, 1'b1, '{STS_DIV_ZERO, 64'd0, 64'd0, 2'b01}},
    '{CMD_LOG, 4'd3, 4'd0, 4'd0, 1'b1, '{STS_LOG_ZERO, 64'd0, 64'd0, 2'b01}},
    // leading zeros of zero
    '{CMD_CLZ, 4'd4, 4'd0, 4'd0, 1'b1, '{STS_OK, 64'd64, 64'd4, 2'b01}},
    '{CMD_INC, 4'd1, 4'd0, 4'd0, 1'b1, '{STS_OK, 64'd1, 64'd8, 2'b01}},
    // subtract of a zero sets the sticky bit
    '{CMD_SUB, 4'd2, 4'd0, 4'd0, 1'b1, '{STS_OK, 64'd0, 64'd12, 2'b11}},
    '{CMD_SUB, 4'd2, 4'd0, 4'd1, 1'b1, '{STS_OK, ALL_ONES, 64'd16, 2'b11}},
    '{CMD_INC, 4'd2, 4'd0, 4'd0, 1'b1, '{STS_INC_OVF, 64'd0, 64'd16, 2'b11}},
    '{CMD_POP, 4'd5, 4'd2, 4'd0, 1'b1, '{STS_OK, 64'd64, 64'd20, 2'b11}},
    // shift by 64 gives zero
    '{CMD_SHL, 4'd6, 4'd2, 4'd5, 1'b1, '{STS_OK, 64'd0, 64'd24, 2'b11}},
    '{CMD_SHR, 4'd7, 4'd2, 4'd1, 1'b1, '{STS_OK, LLONG_MAX_U, 64'd28, 2'b11}},
    // increment right at the signed maximum
    '{CMD_INC, 4'd7, 4'd0, 4'd0, 1'b1, '{STS_INC_OVF, 64'd0, 64'd28, 2'b11}},
    '{CMD_DEC, 4'd7, 4'd0, 4'd0, 1'b1, '{STS_OK, LLONG_MAX_U - 1, 64'd32, 2'b11}},
    '{CMD_INC, 4'd7, 4'd0, 4'd0, 1'b1, '{STS_OK, LLONG_MAX_U, 64'd36, 2'b11}},
    '{CMD_ADD,  4'd8,  4'd2, 4'd1, 1'b0, '0},
    '{CMD_MUL,  4'd9,  4'd7, 4'd7, 1'b0, '0},
    '{CMD_FMA,  4'd9,  4'd2, 4'd7, 1'b0, '0},
    '{CMD_DIV,  4'd10, 4'd2, 4'd7, 1'b0, '0},
    '{CMD_MOD,  4'd11, 4'd2, 4'd7, 1'b0, '0},
    '{CMD_SQRT, 4'd12, 4'd2, 4'd0, 1'b0, '0},
    '{CMD_LOG,  4'd13, 4'd2, 4'd0, 1'b0, '0},
    '{CMD_AND,  4'd14, 4'd2, 4'd9, 1'b0, '0},
    '{CMD_OR,   4'd14, 4'd9, 4'd1, 1'b0, '0},
    '{CMD_XOR,  4'd15, 4'd9, 4'd2, 1'b0, '0},
    '{CMD_ROL,  4'd15, 4'd9, 4'd10, 1'b0, '0},
    '{CMD_ROR,  4'd15, 4'd9, 4'd10, 1'b0, '0},
    '{CMD_CLZ,  4'd4,  4'd1, 4'd0, 1'b0, '0},
    // unused command changes nothing
    '{CMD_SPARE, 4'd15, 4'd15, 4'd15, 1'b0, '0}
  };

  // sends one request, holding it until it is taken
  task automatic send_request(instr_row_t row);
    while (idle_pct_in > 0 && $urandom_range(99) < idle_pct_in) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= row.cmd;
    in_ch.dest_index    <= row.dst;
    in_ch.first_source  <= row.src_a;
    in_ch.second_source <= row.src_b;
    cur_typed           <= row.typed;
    cur_expect          <= row.res;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    instr_row_t row;
    in_ch.valid         = 1'b0;
    in_ch.command       = '0;
    in_ch.dest_index    = '0;
    in_ch.first_source  = '0;
    in_ch.second_source = '0;
    out_ch.ready        = 1'b0;
    cur_typed           = 1'b0;
    cur_expect          = '0;
    done_sending        = 1'b0;
    idle_pct_in         = 0;
    idle_pct_out        = 0;
    foreach (model_regs[i]) model_regs[i] = '0;
    model_ip            = '0;
    model_flags         = '0;
    rst_n               = 1'b0;
    build_ln_bounds();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i]);

    // random part in four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct_in = 0;  idle_pct_out = 0;  end
        1: begin idle_pct_in = 53; idle_pct_out = 0;  end
        2: begin idle_pct_in = 0;  idle_pct_out = 53; end
        default: begin idle_pct_in = 36; idle_pct_out = 36; end
      endcase
      for (int i = 0; i < RAND_ITEMS / 4; i++) begin
        row = '0;
        // mostly real commands, a few from the unused range
        if ($urandom_range(99) < 94) row.cmd = $urandom_range(CMD_LAST);
        else row.cmd = $urandom_range(CMD_SPARE, CMD_LAST + 1);
        row.dst   = $urandom_range(REGS - 1);
        row.src_a = $urandom_range(REGS - 1);
        row.src_b = $urandom_range(REGS - 1);
        send_request(row);
      end
    end
    in_ch.valid  <= 1'b0;
    done_sending <= 1'b1;
  end

  // receiver stalls according to the phase
  always @(posedge clk) begin
    out_ch.ready <= (idle_pct_out == 0) || ($urandom_range(99) >= idle_pct_out);
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on accepted requests, compare accepted results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    alu_result_t exp_r;
    alu_result_t got;
    logic        any_hs;
    if (rst_n) begin
      any_hs = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        exp_r = execute_instr(in_ch.command, in_ch.dest_index,
                              in_ch.first_source, in_ch.second_source);
        // typed rows are checked against the hand-read value
        if (cur_typed) exp_r = cur_expect;
        pending_results.push_back(exp_r);
        cmd_seen[in_ch.command] = 1'b1;
        req_count++;
        any_hs = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        any_hs = 1'b1;
        res_count++;
        got = '{out_ch.status, out_ch.written_value, out_ch.pointer_after,
                out_ch.sticky_flags};
        if (pending_results.size() == 0) begin
          $error("unexpected result, status %0d value %h", got.status, got.value);
          error_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            error_count++;
          end
          if (got.value !== exp_r.value) begin
            $error("written_value: expected %h, got %h", exp_r.value, got.value);
            error_count++;
          end
          if (got.pointer !== exp_r.pointer) begin
            $error("pointer_after: expected %h, got %h", exp_r.pointer, got.pointer);
            error_count++;
          end
          if (got.flags !== exp_r.flags) begin
            $error("sticky_flags: expected %b, got %b", exp_r.flags, got.flags);
            error_count++;
          end
        end
      end
      stall_cycles <= any_hs ? 0 : stall_cycles + 1;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    req_count    = 0;
    res_count    = 0;
    error_count  = 0;
    stall_cycles = 0;
    cmd_seen     = '0;
  end

  // ---------------------------------------------------------------------------
  // end of run
  // ---------------------------------------------------------------------------
  initial begin
    wait (done_sending === 1'b1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_results.size() != 0) error_count++;
    $display("run covered %0d requests and %0d results, %0d distinct commands",
             req_count, res_count, $countones(cmd_seen));
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
